/* rtl/gbb_pkg.sv */
// Shared types, codes and reset constants for the glyph bitmap blitter.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package gbb_pkg;

    localparam int FB_WIDTH_DEF  = 320;
    localparam int FB_HEIGHT_DEF = 240;
    localparam int QUEUE_DEPTH   = 4;

    localparam int PIX_ADDR_W = 17;
    localparam int COLOR_W    = 16;

    // Item function codes.
    localparam logic [1:0] FUNC_BEGIN   = 2'd0;
    localparam logic [1:0] FUNC_BYTE    = 2'd1;
    localparam logic [1:0] FUNC_RETURN  = 2'd2;
    localparam logic [1:0] FUNC_MISSING = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_PIXEL_COLOR    = 2'd0;
    localparam logic [1:0] REG_BACKSPACE_STEP = 2'd1;
    localparam logic [1:0] REG_LINE_ADVANCE   = 2'd2;
    localparam logic [1:0] REG_LEFT_MARGIN    = 2'd3;

    localparam logic [15:0] PIXEL_COLOR_RST    = 16'hFFFF;
    localparam logic [7:0]  BACKSPACE_STEP_RST = 8'd12;
    localparam logic [7:0]  LINE_ADVANCE_RST   = 8'd32;
    localparam logic [7:0]  LEFT_MARGIN_RST    = 8'd8;
    localparam logic [15:0] CURSOR_RST         = 16'd8;

    // One expanded byte: in-range set bits (MSB is leftmost pixel) and the
    // frame buffer address of the leftmost pixel.
    typedef struct packed {
        logic [7:0]            mask;
        logic [PIX_ADDR_W-1:0] base;
    } t_job;

endpackage

`default_nettype wire

/* rtl/gbb_front.sv */
// Front end: takes items, keeps the cursor and glyph counters, and turns each
// drawable bitmap byte into a job for the queue. Depends on gbb_pkg.
`default_nettype none

module gbb_front
    import gbb_pkg::*;
#(
    parameter int FB_WIDTH  = FB_WIDTH_DEF,
    parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_glyph_width,
    input  wire logic [7:0] i_glyph_height,
    input  wire logic [7:0] i_bitmap_byte,
    input  wire logic [7:0] i_backspace_step,
    input  wire logic [7:0] i_line_advance,
    input  wire logic [7:0] i_left_margin,
    output logic            o_job_push,
    output t_job            o_job
);

    localparam int BASE_W = 18 + $clog2(FB_WIDTH);
    localparam logic [BASE_W-1:0] FB_W_B  = BASE_W'(FB_WIDTH);
    localparam logic [BASE_W-1:0] LIMIT_B = BASE_W'(FB_WIDTH * FB_HEIGHT);
    localparam logic [15:0] HALF_W        = 16'(FB_WIDTH / 2);
    localparam logic signed [17:0] FB_H_S = 18'(FB_HEIGHT);

    logic [15:0]       r_cursor_x, r_cursor_y;
    logic [BASE_W-1:0] r_row_base;
    logic [7:0]        r_glyph_cols, r_glyph_rows, r_row_index;
    logic [5:0]        r_byte_in_row;
    logic              r_draw_enable;

    logic signed [17:0] guard;
    logic               blocked;
    logic [BASE_W-1:0]  byte_base;
    logic [BASE_W-1:0]  begin_base;
    logic [5:0]         bytes_per_row;
    logic [5:0]         n_byte_in_row;
    logic [7:0]         n_row_index;
    logic               row_done;
    logic [7:0]         mask;

    assign guard         = FB_H_S - $signed({10'b0, i_line_advance});
    assign blocked       = $signed({2'b00, r_cursor_y}) > guard;
    assign begin_base    = BASE_W'(r_cursor_y) * FB_W_B + BASE_W'(r_cursor_x);
    assign byte_base     = r_row_base + BASE_W'({r_byte_in_row, 3'b000});
    assign bytes_per_row = 6'(({1'b0, r_glyph_cols} + 9'd7) >> 3);
    assign n_byte_in_row = r_byte_in_row + 6'd1;
    assign n_row_index   = r_row_index + 8'd1;
    assign row_done      = n_byte_in_row >= bytes_per_row;

    // Addresses rise from the MSB toward the LSB, so each bit is checked on its own.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            mask[7-b] = i_bitmap_byte[7-b] && ((byte_base + BASE_W'(b)) < LIMIT_B);
        end
    end

    assign o_job_push = i_accept && (i_func == FUNC_BYTE) && r_draw_enable && (mask != 8'd0);
    assign o_job.mask = mask;
    assign o_job.base = byte_base[PIX_ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x    <= CURSOR_RST;
            r_cursor_y    <= CURSOR_RST;
            r_row_base    <= '0;
            r_glyph_cols  <= 8'd0;
            r_glyph_rows  <= 8'd0;
            r_row_index   <= 8'd0;
            r_byte_in_row <= 6'd0;
            r_draw_enable <= 1'b0;
        end else if (i_accept) begin
            unique case (i_func)
                FUNC_BEGIN: begin
                    if (blocked) begin
                        r_draw_enable <= 1'b0;
                    end else begin
                        r_glyph_cols  <= i_glyph_width;
                        r_glyph_rows  <= i_glyph_height;
                        r_row_base    <= begin_base;
                        r_row_index   <= 8'd0;
                        r_byte_in_row <= 6'd0;
                        r_draw_enable <= (i_glyph_width != 8'd0) && (i_glyph_height != 8'd0);
                    end
                end
                FUNC_BYTE: begin
                    if (r_draw_enable) begin
                        if (row_done) begin
                            r_byte_in_row <= 6'd0;
                            r_row_index   <= n_row_index;
                            r_row_base    <= r_row_base + FB_W_B;
                            if (n_row_index >= r_glyph_rows) begin
                                r_draw_enable <= 1'b0;
                            end
                        end else begin
                            r_byte_in_row <= n_byte_in_row;
                        end
                    end
                end
                FUNC_RETURN: begin
                    if (r_cursor_x < HALF_W) begin
                        r_cursor_x <= r_cursor_x + HALF_W;
                    end else begin
                        r_cursor_x <= {8'b0, i_left_margin};
                        r_cursor_y <= r_cursor_y + {8'b0, i_line_advance};
                    end
                end
                FUNC_MISSING: begin
                    r_cursor_x <= r_cursor_x - {8'b0, i_backspace_step};
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/gbb_queue.sv */
// Short job queue between the front end and the pixel writer.
// Depends on gbb_pkg for the job type.
`default_nettype none

module gbb_queue
    import gbb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == DEPTH_C;
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("job queue holds more entries than its depth");
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("job queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

/* rtl/gbb_back.sv */
// Back end: walks the set bits of each job MSB first and writes one pixel
// per cycle into the output register while it is free or popped. Depends on gbb_pkg.
`default_nettype none

module gbb_back
    import gbb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_empty,
    input  t_job                       i_q_job,
    output logic                       o_q_pop,
    input  wire logic [COLOR_W-1:0]    i_pixel_color,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [PIX_ADDR_W-1:0]      o_pixel_address,
    output logic [COLOR_W-1:0]         o_pixel_value,
    output logic                       o_last
);

    logic [7:0]            r_mask;
    logic [PIX_ADDR_W-1:0] r_base;
    logic                  r_out_valid;
    logic [PIX_ADDR_W-1:0] r_out_addr;
    logic [COLOR_W-1:0]    r_out_value;
    logic                  r_out_last;

    logic       job_valid, out_free, advance, job_load, found;
    logic [2:0] lead_idx;
    logic [7:0] rest;

    always_comb begin
        lead_idx = 3'd0;
        found    = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (!found && r_mask[7-b]) begin
                lead_idx = 3'(b);
                found    = 1'b1;
            end
        end
    end

    assign rest      = r_mask & ~(8'h80 >> lead_idx);
    assign job_valid = r_mask != 8'd0;
    assign out_free  = !r_out_valid || i_pop;
    assign advance   = job_valid && out_free;
    assign job_load  = !i_q_empty && (!job_valid || (advance && (rest == 8'd0)));
    assign o_q_pop   = job_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 8'd0;
        end else if (job_load) begin
            r_mask <= i_q_job.mask;
        end else if (advance) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_load) begin
            r_base <= i_q_job.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_addr  <= r_base + PIX_ADDR_W'(lead_idx);
            r_out_value <= i_pixel_color;
            r_out_last  <= rest == 8'd0;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_value   = r_out_value;
    assign o_last          = r_out_last;

`ifndef NO_ASSERTIONS
    a_more_to_come: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> job_valid)
        else $error("non-final pixel shown but its byte has no bits left");
    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("pixel write was lost on its way to the output register");
`endif

endmodule

`default_nettype wire

/* rtl/glyph_bitmap_blitter.sv */
// Glyph bitmap blitter: a bitmap byte goes from the job queue to the writer's
// mask register and then to its output register. The front end takes one item
// per cycle while the queue is not full; the writer emits one write per cycle
// while popped; n in-range set bits (up to 8) give n writes, and the queue absorbs bursts.
// Reset is synchronous (i_rst_n low): cursor to (8,8), no glyph active,
// registers to defaults, queue and output empty. No memory clearing is needed.
`default_nettype none

module glyph_bitmap_blitter
    import gbb_pkg::*;
#(
    parameter int FB_WIDTH  = FB_WIDTH_DEF,
    parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Item side: behaves as the write end of a queue.
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             i_func,
    input  wire logic [7:0]             i_glyph_width,
    input  wire logic [7:0]             i_glyph_height,
    input  wire logic [7:0]             i_bitmap_byte,
    // Result side: behaves as the read end of a queue.
    output logic                        empty,
    input  wire logic                   pop,
    output logic [PIX_ADDR_W-1:0]       o_pixel_address,
    output logic [COLOR_W-1:0]          o_pixel_value,
    output logic                        o_last,
    // Register port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // Configuration registers. The user must change them only while the block
    // is idle; the block does not enforce this, and the pipeline reads them directly.
    logic [15:0] r_pixel_color;
    logic [7:0]  r_backspace_step;
    logic [7:0]  r_line_advance;
    logic [7:0]  r_left_margin;

    logic       cfg_write;
    logic [1:0] reg_index;

    logic in_accept;
    logic job_push, q_full, q_empty, q_pop;
    t_job job_in, job_out;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_color    <= PIXEL_COLOR_RST;
            r_backspace_step <= BACKSPACE_STEP_RST;
            r_line_advance   <= LINE_ADVANCE_RST;
            r_left_margin    <= LEFT_MARGIN_RST;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_PIXEL_COLOR:    r_pixel_color    <= pwdata[15:0];
                REG_BACKSPACE_STEP: r_backspace_step <= pwdata[7:0];
                REG_LINE_ADVANCE:   r_line_advance   <= pwdata[7:0];
                REG_LEFT_MARGIN:    r_left_margin    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_PIXEL_COLOR:    prdata = {16'b0, r_pixel_color};
            REG_BACKSPACE_STEP: prdata = {24'b0, r_backspace_step};
            REG_LINE_ADVANCE:   prdata = {24'b0, r_line_advance};
            REG_LEFT_MARGIN:    prdata = {24'b0, r_left_margin};
            default:            prdata = 32'd0;
        endcase
    end

    // Every item waits for queue space, which keeps item order simple; items
    // that draw nothing just update the cursor or glyph state.
    assign full      = q_full;
    assign in_accept = push && !q_full;

    gbb_front #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_func           (i_func),
        .i_glyph_width    (i_glyph_width),
        .i_glyph_height   (i_glyph_height),
        .i_bitmap_byte    (i_bitmap_byte),
        .i_backspace_step (r_backspace_step),
        .i_line_advance   (r_line_advance),
        .i_left_margin    (r_left_margin),
        .o_job_push       (job_push),
        .o_job            (job_in)
    );

    gbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    // The writer's output register is the result queue head; it refills in
    // the same cycle it is popped, so writes stream at one per cycle while jobs are waiting.
    gbb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_job         (job_out),
        .o_q_pop         (q_pop),
        .i_pixel_color   (r_pixel_color),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

/* verif/gbb_tb_pkg.sv */
// Scoreboard for the glyph bitmap blitter testbench: a cycle-free model of the
// blitter state and a queue of the pixel writes it predicts.
// Depends on rtl/gbb_pkg.sv for codes, widths and reset values.

package gbb_tb_pkg;
    import gbb_pkg::*;

    typedef struct packed {
        logic [PIX_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]    value;
        logic                  last;
    } pixel_write_t;

    class blit_scoreboard;
        logic [15:0]  color_reg;
        logic [7:0]   backspace_reg;
        logic [7:0]   advance_reg;
        logic [7:0]   margin_reg;
        logic [15:0]  cur_x;
        logic [15:0]  cur_y;
        logic [15:0]  org_x;
        logic [15:0]  org_y;
        logic [7:0]   cols;
        logic [7:0]   rows;
        logic [7:0]   row_idx;
        logic [5:0]   col_byte;
        logic         drawing;
        pixel_write_t pending_writes[$];
        int           errors;

        function new();
            color_reg     = PIXEL_COLOR_RST;
            backspace_reg = BACKSPACE_STEP_RST;
            advance_reg   = LINE_ADVANCE_RST;
            margin_reg    = LEFT_MARGIN_RST;
            cur_x         = CURSOR_RST;
            cur_y         = CURSOR_RST;
            org_x         = '0;
            org_y         = '0;
            cols          = '0;
            rows          = '0;
            row_idx       = '0;
            col_byte      = '0;
            drawing       = 1'b0;
            errors        = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_PIXEL_COLOR:    color_reg = data[15:0];
                REG_BACKSPACE_STEP: backspace_reg = data[7:0];
                REG_LINE_ADVANCE:   advance_reg = data[7:0];
                default:            margin_reg = data[7:0];
            endcase
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction

        // Expands one bitmap byte at the current row position into writes.
        function void expand_byte(logic [7:0] bits);
            longint       y;
            longint       xbase;
            longint       addr;
            pixel_write_t burst[$];
            pixel_write_t wr;
            y = longint'(org_y) + longint'(row_idx);
            xbase = longint'(org_x) + 8 * longint'(col_byte);
            for (int b = 0; b < 8; b++) begin
                if (bits[7 - b]) begin
                    addr = xbase + b + y * FB_WIDTH_DEF;
                    if (addr < longint'(FB_WIDTH_DEF) * FB_HEIGHT_DEF) begin
                        wr.addr  = addr[PIX_ADDR_W-1:0];
                        wr.value = color_reg;
                        wr.last  = 1'b0;
                        burst.push_back(wr);
                    end
                end
            end
            if (burst.size() > 0) begin
                burst[burst.size() - 1].last = 1'b1;
            end
            foreach (burst[i]) pending_writes.push_back(burst[i]);
        endfunction

        // Applies one accepted item; returns 0 when the block ignores it.
        function bit note_item(logic [1:0] func, logic [7:0] w, logic [7:0] h,
                               logic [7:0] bits);
            bit effective;
            effective = 1'b1;
            case (func)
                FUNC_BEGIN: begin
                    if (int'(cur_y) > FB_HEIGHT_DEF - int'(advance_reg)) begin
                        drawing = 1'b0;
                    end else begin
                        cols     = w;
                        rows     = h;
                        org_x    = cur_x;
                        org_y    = cur_y;
                        row_idx  = '0;
                        col_byte = '0;
                        drawing  = (w != 8'd0) && (h != 8'd0);
                    end
                end
                FUNC_BYTE: begin
                    if (drawing) begin
                        expand_byte(bits);
                        col_byte = col_byte + 6'd1;
                        if (int'(col_byte) >= (int'(cols) + 7) / 8) begin
                            col_byte = '0;
                            row_idx  = row_idx + 8'd1;
                            if (row_idx >= rows) begin
                                drawing = 1'b0;
                            end
                        end
                    end else begin
                        effective = 1'b0;
                    end
                end
                FUNC_RETURN: begin
                    if (int'(cur_x) < FB_WIDTH_DEF / 2) begin
                        cur_x = cur_x + 16'(FB_WIDTH_DEF / 2);
                    end else begin
                        cur_x = {8'd0, margin_reg};
                        cur_y = cur_y + 16'(advance_reg);
                    end
                end
                default: cur_x = cur_x - 16'(backspace_reg);
            endcase
            return effective;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("tb: mismatch at %0t: %s", $time, msg);
            end
        endtask

        task check_write(logic [PIX_ADDR_W-1:0] addr, logic [COLOR_W-1:0] value,
                         logic last);
            pixel_write_t exp_w;
            if (pending_writes.size() == 0) begin
                report($sformatf("unexpected write addr=%0d value=%h", addr, value));
                return;
            end
            exp_w = pending_writes.pop_front();
            if (addr !== exp_w.addr) begin
                report($sformatf("address %0d, predicted %0d", addr, exp_w.addr));
            end
            if (value !== exp_w.value) begin
                report($sformatf("value %h at %0d, predicted %h", value, exp_w.addr,
                                 exp_w.value));
            end
            if (last !== exp_w.last) begin
                report($sformatf("last %b at %0d, predicted %b", last, exp_w.addr,
                                 exp_w.last));
            end
        endtask
    endclass

endpackage

/* verif/testbench.sv */
// Self-checking testbench for glyph_bitmap_blitter: directed glyph streams,
// a cursor wrap-around pass and random glyph phases, checked write by write.
// Depends on rtl/gbb_pkg.sv, the RTL top level and verif/gbb_tb_pkg.sv.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gbb_pkg::*;
    import gbb_tb_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 120;
    localparam int RANDOM_PHASES = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [1:0]            i_func = FUNC_BEGIN;
    logic [7:0]            i_glyph_width = '0;
    logic [7:0]            i_glyph_height = '0;
    logic [7:0]            i_bitmap_byte = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [PIX_ADDR_W-1:0] o_pixel_address;
    logic [COLOR_W-1:0]    o_pixel_value;
    logic                  o_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    blit_scoreboard sb;

    // Sender burst bookkeeping and the count of items that changed the block.
    int burst_left = 0;
    int items_effective = 0;

    // Receiver stall pattern: a 16-bit ring that is replaced now and then.
    logic [15:0] pop_pattern = 16'hFFFF;
    int          pattern_hold = 0;

    glyph_bitmap_blitter uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses writes.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side. A transfer happens at an edge where pop was high and empty
    // low; both are sampled here before the edge's updates land, so the check
    // sees exactly what the block saw. The pop pattern rotates every cycle and
    // is swapped for another one after a random hold time, which mixes full
    // speed stretches with regular and bursty stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                sb.check_write(o_pixel_address, o_pixel_value, o_last);
            end
            if (pattern_hold == 0) begin
                case ($urandom_range(0, 3))
                    0:       pop_pattern = 16'hFFFF;
                    1:       pop_pattern = 16'($urandom) | 16'h0001;
                    2:       pop_pattern = 16'h0101;
                    default: pop_pattern = 16'h00FF;
                endcase
                pattern_hold = $urandom_range(32, 256);
            end else begin
                pattern_hold--;
            end
            pop <= pop_pattern[0];
            pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
        end
    end

    // Presents one item and waits for its transfer. Sender gaps are inserted
    // only between bursts; within a burst push stays high from item to item,
    // so push gets a single update per time step. Returns right at the edge
    // that took the item, which is where the prediction is advanced.
    task automatic send_item(input logic [1:0] func, input logic [7:0] w,
                             input logic [7:0] h, input logic [7:0] bits);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push           <= 1'b1;
        i_func         <= func;
        i_glyph_width  <= w;
        i_glyph_height <= h;
        i_bitmap_byte  <= bits;
        do @(posedge i_clk); while (full);
        if (sb.note_item(func, w, h, bits)) begin
            items_effective++;
        end
    endtask

    // One register write: setup cycle, then access cycle until pready.
    // The select lines are left up so that back-to-back writes need no
    // second update of psel in the same step.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, data);
    endtask

    // Writes all four registers. The unused upper bits carry random junk,
    // which the block must drop.
    task automatic program_registers(input logic [15:0] color,
                                     input logic [7:0] backspace,
                                     input logic [7:0] advance,
                                     input logic [7:0] margin);
        write_register(REG_PIXEL_COLOR, {16'($urandom), color});
        write_register(REG_BACKSPACE_STEP, {24'($urandom), backspace});
        write_register(REG_LINE_ADVANCE, {24'($urandom), advance});
        write_register(REG_LEFT_MARGIN, {24'($urandom), margin});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops the sender and waits for every predicted write, then gives the
    // pipeline time to retire items that produce no writes at all (blocked
    // glyphs, clear bytes, cursor moves) before any register changes.
    task automatic settle_block();
        push <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A return that wraps to a new line moves the cursor down for good, so
    // the random part only wraps while the cursor stays well above the
    // bottom guard band; otherwise every later glyph would be blocked.
    function automatic bit return_allowed();
        return (int'(sb.cur_x) < FB_WIDTH_DEF / 2) ||
               (int'(sb.cur_y) + int'(sb.advance_reg) <= 200);
    endfunction

    // A well-formed glyph: begin, its bitmap bytes, then sometimes a cursor move.
    // Mostly small glyphs; one of more than 24 bytes is cut to 8 to 24 bytes,
    // and now and then one spare byte is added at the end.
    task automatic send_random_glyph();
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] bits;
        int         nbytes;
        int         pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) w = 8'($urandom);
        else if (pick < 4) w = 8'($urandom_range(25, 255));
        else w = 8'($urandom_range(1, 24));
        pick = $urandom_range(0, 19);
        if (pick == 0) h = 8'($urandom);
        else if (pick < 3) h = 8'($urandom_range(13, 255));
        else h = 8'($urandom_range(1, 12));
        send_item(FUNC_BEGIN, w, h, 8'($urandom));
        nbytes = ((int'(w) + 7) / 8) * int'(h);
        if (nbytes > 24) nbytes = $urandom_range(8, 24);
        if ($urandom_range(0, 3) == 0) nbytes++;
        repeat (nbytes) begin
            pick = $urandom_range(0, 7);
            bits = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            send_item(FUNC_BYTE, 8'($urandom), 8'($urandom), bits);
        end
        pick = $urandom_range(0, 5);
        if (pick < 2) begin
            send_item(FUNC_MISSING, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 4 && return_allowed()) begin
            send_item(FUNC_RETURN, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // A stray item of any kind with random fields.
    task automatic send_noise_item();
        logic [1:0] func;
        func = 2'($urandom);
        if (func == FUNC_RETURN && !return_allowed()) func = FUNC_MISSING;
        send_item(func, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        int target;
        int prev_y;
        int row_gap;
        int slack;
        int waited;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values. Cursor starts at (8,8).
        // A two-row glyph, then a byte after its last row that must be ignored.
        send_item(FUNC_BEGIN, 8'd8, 8'd2, 8'h00);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'h81);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        // Zero width and zero height glyphs draw nothing.
        send_item(FUNC_BEGIN, 8'd0, 8'd3, 8'h00);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        send_item(FUNC_BEGIN, 8'd9, 8'd0, 8'h00);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        // Backspace past column zero wraps the cursor far to the right; the
        // widest and tallest glyph there spills linearly into later rows.
        send_item(FUNC_MISSING, 8'hFF, 8'hFF, 8'hFF);
        send_item(FUNC_BEGIN, 8'd255, 8'd255, 8'h00);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'h01);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'h80);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'h00);
        // Wrap to a new line from a far-right cursor, then a half-screen jump.
        send_item(FUNC_RETURN, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_RETURN, 8'd0, 8'd0, 8'd0);
        settle_block();

        // A big line advance pushes the cursor to the last row and also
        // raises the guard band, so the next glyph is blocked.
        program_registers(16'hA5A5, 8'd12, 8'd199, 8'd156);
        send_item(FUNC_RETURN, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_RETURN, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_BEGIN, 8'd8, 8'd8, 8'h00);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        settle_block();

        // Smallest line advance: drawing on the last row is allowed again.
        // The first byte straddles the end of the buffer, so only its left
        // half is written and the end-of-byte flag moves to the last written
        // pixel; the rest of the glyph lies past the buffer. Color is zero
        // and a zero backspace leaves the cursor in place.
        program_registers(16'h0000, 8'd0, 8'd1, 8'd156);
        send_item(FUNC_MISSING, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_BEGIN, 8'd16, 8'd2, 8'h00);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        send_item(FUNC_BYTE, 8'd0, 8'd0, 8'hFF);
        send_item(FUNC_RETURN, 8'd0, 8'd0, 8'd0);
        settle_block();

        // Cursor row wrap-around: the largest line advance walks the row
        // counter up through its whole range. The left margin lies past the
        // half-screen column, so every return after the first wraps a line.
        // Once the row is close to the top, a tailored advance brings it
        // back to a small row for drawing.
        program_registers(16'h5A5A, 8'd200, 8'd255, 8'd200);
        do begin
            prev_y = int'(sb.cur_y);
            send_item(FUNC_RETURN, 8'($urandom), 8'($urandom), 8'($urandom));
        end while (int'(sb.cur_y) >= prev_y && int'(sb.cur_y) < 65282);
        if (int'(sb.cur_y) >= 65282) begin
            settle_block();
            row_gap = 65536 - int'(sb.cur_y);
            slack = 255 - row_gap;
            if (slack > 16) slack = 16;
            program_registers(16'($urandom), 8'($urandom),
                              8'(row_gap + $urandom_range(0, slack)), 8'($urandom));
            while (sb.cur_y >= 16'd65282) begin
                send_item(FUNC_RETURN, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        // Random phases, each with its own register setting. The first two
        // take the extreme values; the third a large line advance so that
        // the guard band blocks some glyphs.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_block();
            case (ph)
                0: program_registers(16'h0000, 8'd255, 8'd1, 8'd0);
                1: program_registers(16'hFFFF, 8'd0, 8'($urandom_range(1, 24)), 8'd255);
                2: program_registers(16'($urandom), 8'($urandom),
                                     8'($urandom_range(25, 80)), 8'($urandom));
                default: program_registers(16'($urandom), 8'($urandom),
                                           8'($urandom_range(1, 24)), 8'($urandom));
            endcase
            target = items_effective + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_effective < target) begin
                if ($urandom_range(0, 99) < 15) send_noise_item();
                else send_random_glyph();
            end
        end

        // Drain, then watch a little longer for stray writes.
        push <= 1'b0;
        waited = 0;
        while (sb.outstanding() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.outstanding() > 0) begin
            sb.report($sformatf("%0d predicted writes never arrived", sb.outstanding()));
        end
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
